// ===== hw/rtl/hrec_pkg.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record encoder package
// Shared payload types, command format and character helpers.
// ----------------------------------------------------------------------------
package hrec_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] load_address;
        logic [4:0]  byte_count;
        logic [7:0]  data_byte;
    } hrec_in_t;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       end_of_line;
    } hrec_out_t;

    // One classified request handed from the front end to the back end.
    typedef struct packed {
        logic        eof;
        logic        open;
        logic        close;
        logic [4:0]  length;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  checksum;
    } hrec_cmd_t;

    localparam logic [0:0] MODE_DATA = 1'b0;
    localparam logic [0:0] MODE_EOF  = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0] DIGIT_BASE  = 8'h30;
    localparam logic [7:0] LETTER_BASE = 8'h37;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    localparam int unsigned EOF_LEN = 12;
    localparam logic [7:0] EOF_TEXT [EOF_LEN] = '{
        8'h3A, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
        8'h30, 8'h30, 8'h31, 8'h46, 8'h46, 8'h0A
    };

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] n;
        n = {4'h0, nib};
        return (nib <= 4'd9) ? (n + DIGIT_BASE) : (n + LETTER_BASE);
    endfunction

endpackage

// ===== hw/rtl/hex_record_encoder_core.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record encoder core
// Turns data bytes and end-of-file requests into Intel HEX record text.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  s_        in         s_valid/s_ready    mode, load_address, byte_count, data_byte
//  m_        out        m_valid/m_ready    ascii_char, end_of_line
//
// The output runs at one character per cycle while m_ready does not stall it. A data byte gives two characters,
// plus nine for the record header on its first byte and three for the checksum
// and newline on its last; an end-of-file request gives twelve.
// A two-entry command queue lets requests be taken while characters drain.
// Reset is synchronous and clears the open record, the command queue and the
// back end.
// Stalls on m_ready hold the output register and back up through the queue.
module hex_record_encoder_core #(
    parameter int MAX_RECORD_BYTES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrec_pkg::hrec_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output hrec_pkg::hrec_out_t m_payload
);
    import hrec_pkg::*;

    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    hrec_cmd_t  wr_cmd;
    hrec_cmd_t  rd_cmd;

    hrec_front #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (wr_cmd)
    );

    hrec_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (wr_cmd),
        .pop     (q_pop),
        .rd_data (rd_cmd),
        .full    (q_full),
        .empty   (q_empty)
    );

    hrec_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_data    (rd_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ===== hw/rtl/hrec_front.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record encoder front end
// Accepts requests, tracks the open record and builds one command per request.
// ----------------------------------------------------------------------------
module hrec_front #(
    parameter int MAX_RECORD_BYTES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hrec_pkg::hrec_in_t s_payload,
    input  logic               q_full,
    output logic               q_push,
    output hrec_pkg::hrec_cmd_t q_data
);
    import hrec_pkg::*;

    localparam logic [7:0] MAX_W = 8'(MAX_RECORD_BYTES);

    logic [4:0] bytes_done_reg, bytes_done_next;
    logic [4:0] record_length_reg, record_length_next;
    logic [7:0] running_sum_reg, running_sum_next;

    logic       accept;
    logic       first;
    logic [4:0] cnt_sat;
    logic [4:0] len;
    logic [7:0] sum_base;
    logic [7:0] sum;
    logic [4:0] done_inc;
    logic       close;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    always_comb begin
        first = (bytes_done_reg == 5'd0);
        if (s_payload.byte_count == 5'd0) begin
            cnt_sat = 5'd1;
        end else if ({3'b000, s_payload.byte_count} > MAX_W) begin
            cnt_sat = MAX_W[4:0];
        end else begin
            cnt_sat = s_payload.byte_count;
        end
        len      = first ? cnt_sat : record_length_reg;
        sum_base = first ? ({3'b000, len} + s_payload.load_address[15:8]
                            + s_payload.load_address[7:0])
                         : running_sum_reg;
        sum      = sum_base + s_payload.data_byte;
        done_inc = bytes_done_reg + 5'd1;
        close    = (done_inc >= len) || (done_inc == 5'd0);

        q_data.eof      = (s_payload.mode == MODE_EOF);
        q_data.open     = first;
        q_data.close    = close;
        q_data.length   = len;
        q_data.address  = s_payload.load_address;
        q_data.data     = s_payload.data_byte;
        q_data.checksum = 8'd0 - sum;

        bytes_done_next    = bytes_done_reg;
        record_length_next = record_length_reg;
        running_sum_next   = running_sum_reg;
        if (accept) begin
            if (s_payload.mode == MODE_EOF) begin
                bytes_done_next    = 5'd0;
                record_length_next = 5'd0;
                running_sum_next   = 8'd0;
            end else begin
                record_length_next = len;
                bytes_done_next    = close ? 5'd0 : done_inc;
                running_sum_next   = close ? 8'd0 : sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_done_reg    <= 5'd0;
            record_length_reg <= 5'd0;
            running_sum_reg   <= 8'd0;
        end else begin
            bytes_done_reg    <= bytes_done_next;
            record_length_reg <= record_length_next;
            running_sum_reg   <= running_sum_next;
        end
    end

endmodule

// ===== hw/rtl/hrec_queue.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record encoder command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module hrec_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hrec_pkg::hrec_cmd_t wr_data,
    input  logic                pop,
    output hrec_pkg::hrec_cmd_t rd_data,
    output logic                full,
    output logic                empty
);
    import hrec_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

    hrec_cmd_t         entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full    = (count_reg == DEPTH_C);
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hw/rtl/hrec_back.sv =====
// ----------------------------------------------------------------------------
// Intel HEX record encoder back end
// Steps through each command one character per cycle into the output register, unless m_ready stalls it.
// ----------------------------------------------------------------------------
module hrec_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  hrec_pkg::hrec_cmd_t q_data,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output hrec_pkg::hrec_out_t m_payload
);
    import hrec_pkg::*;

    localparam logic [3:0] POS_COLON   = 4'd0;
    localparam logic [3:0] POS_LEN_HI  = 4'd1;
    localparam logic [3:0] POS_LEN_LO  = 4'd2;
    localparam logic [3:0] POS_AH_HI   = 4'd3;
    localparam logic [3:0] POS_AH_LO   = 4'd4;
    localparam logic [3:0] POS_AL_HI   = 4'd5;
    localparam logic [3:0] POS_AL_LO   = 4'd6;
    localparam logic [3:0] POS_TYPE_HI = 4'd7;
    localparam logic [3:0] POS_TYPE_LO = 4'd8;
    localparam logic [3:0] POS_DAT_HI  = 4'd9;
    localparam logic [3:0] POS_DAT_LO  = 4'd10;
    localparam logic [3:0] POS_CS_HI   = 4'd11;
    localparam logic [3:0] POS_CS_LO   = 4'd12;
    localparam logic [3:0] POS_NL      = 4'd13;
    localparam logic [3:0] POS_EOF_END = 4'(EOF_LEN - 1);

    hrec_cmd_t  cmd_reg, cmd_next;
    logic       busy_reg, busy_next;
    logic [3:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    hrec_out_t  out_reg, out_next;

    logic       take;
    logic       last;
    logic       load;
    hrec_out_t  cur;
    logic [7:0] len_byte;

    always_comb begin
        len_byte        = {3'b000, cmd_reg.length};
        cur.end_of_line = 1'b0;
        if (cmd_reg.eof) begin
            cur.ascii_char  = EOF_TEXT[idx_reg];
            cur.end_of_line = (idx_reg == POS_EOF_END);
            last            = (idx_reg == POS_EOF_END);
        end else begin
            last = cmd_reg.close ? (idx_reg == POS_NL) : (idx_reg == POS_DAT_LO);
            case (idx_reg)
                POS_COLON:   cur.ascii_char = CHAR_COLON;
                POS_LEN_HI:  cur.ascii_char = hex_char(len_byte[7:4]);
                POS_LEN_LO:  cur.ascii_char = hex_char(len_byte[3:0]);
                POS_AH_HI:   cur.ascii_char = hex_char(cmd_reg.address[15:12]);
                POS_AH_LO:   cur.ascii_char = hex_char(cmd_reg.address[11:8]);
                POS_AL_HI:   cur.ascii_char = hex_char(cmd_reg.address[7:4]);
                POS_AL_LO:   cur.ascii_char = hex_char(cmd_reg.address[3:0]);
                POS_TYPE_HI: cur.ascii_char = CHAR_ZERO;
                POS_TYPE_LO: cur.ascii_char = CHAR_ZERO;
                POS_DAT_HI:  cur.ascii_char = hex_char(cmd_reg.data[7:4]);
                POS_DAT_LO:  cur.ascii_char = hex_char(cmd_reg.data[3:0]);
                POS_CS_HI:   cur.ascii_char = hex_char(cmd_reg.checksum[7:4]);
                POS_CS_LO:   cur.ascii_char = hex_char(cmd_reg.checksum[3:0]);
                POS_NL: begin
                    cur.ascii_char  = CHAR_LF;
                    cur.end_of_line = 1'b1;
                end
                default:     cur.ascii_char = CHAR_LF;
            endcase
        end

        take  = busy_reg && (!m_valid_reg || m_ready);
        load  = (!busy_reg || (take && last)) && !q_empty;
        q_pop = load;

        cmd_next     = cmd_reg;
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (take) begin
            out_next     = cur;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (load) begin
            cmd_next  = q_data;
            busy_next = 1'b1;
            idx_next  = (q_data.eof || q_data.open) ? POS_COLON : POS_DAT_HI;
        end else if (take) begin
            if (last) begin
                busy_next = 1'b0;
            end else begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= POS_COLON;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        out_reg <= out_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intel HEX record encoder testbench
// Drives data-byte and end-of-file requests into the encoder core and
// predicts the record text character by character. Every received
// character is checked against the prediction. Both sides idle at random,
// and the receiver can hold off long enough to stall the input.
// ----------------------------------------------------------------------------
module testbench;
    import hrec_pkg::*;

    localparam int          MAX_BYTES     = 16;
    localparam int          RANDOM_ITEMS  = 230;
    localparam logic [7:0]  REC_TYPE_DATA = 8'h00;
    localparam logic [7:0]  REC_TYPE_EOF  = 8'h01;

    // Predicts the text of each record and checks it as it arrives.
    class hex_text_scoreboard;
        hrec_out_t  text_queue[$];
        logic [4:0] open_bytes = '0;
        logic [4:0] rec_len    = '0;
        logic [7:0] sum_acc    = '0;
        int         errors     = 0;
        int         checked    = 0;
        int         closed     = 0;
        int         eof_seen   = 0;

        function logic [7:0] nibble_ascii(logic [3:0] nib);
            if (nib < 4'd10) begin
                return 8'h30 + {4'h0, nib};
            end
            return 8'h41 + {4'h0, nib} - 8'd10;
        endfunction

        function void push_char(logic [7:0] c, logic eol);
            hrec_out_t o;
            o.ascii_char  = c;
            o.end_of_line = eol;
            text_queue.push_back(o);
        endfunction

        function void push_hex(logic [7:0] b);
            push_char(nibble_ascii(b[7:4]), 1'b0);
            push_char(nibble_ascii(b[3:0]), 1'b0);
        endfunction

        function void note_request(hrec_in_t r);
            logic [4:0] len;
            if (r.mode == MODE_EOF) begin
                open_bytes = '0;
                rec_len    = '0;
                sum_acc    = '0;
                push_char(":", 1'b0);
                push_hex(8'h00);
                push_hex(8'h00);
                push_hex(8'h00);
                push_hex(REC_TYPE_EOF);
                push_hex(8'hFF);
                push_char(8'h0A, 1'b1);
                eof_seen++;
                return;
            end
            if (open_bytes == 0) begin
                len = r.byte_count;
                if (len == 0) begin
                    len = 5'd1;
                end
                if (len > MAX_BYTES) begin
                    len = 5'(MAX_BYTES);
                end
                rec_len = len;
                push_char(":", 1'b0);
                push_hex({3'b000, len});
                push_hex(r.load_address[15:8]);
                push_hex(r.load_address[7:0]);
                push_hex(REC_TYPE_DATA);
                sum_acc = {3'b000, len} + r.load_address[15:8] + r.load_address[7:0];
            end
            push_hex(r.data_byte);
            sum_acc    = sum_acc + r.data_byte;
            open_bytes = open_bytes + 5'd1;
            if (open_bytes >= rec_len) begin
                push_hex(8'h00 - sum_acc);
                push_char(8'h0A, 1'b1);
                open_bytes = '0;
                sum_acc    = '0;
                closed++;
            end
        endfunction

        function void check_char(hrec_out_t got);
            hrec_out_t want;
            if (text_queue.size() == 0) begin
                $error("unexpected character 0x%02h with no request outstanding",
                       got.ascii_char);
                errors++;
                return;
            end
            want = text_queue.pop_front();
            checked++;
            if (got.ascii_char !== want.ascii_char) begin
                $error("ascii_char: expected 0x%02h, actual 0x%02h",
                       want.ascii_char, got.ascii_char);
                errors++;
            end
            if (got.end_of_line !== want.end_of_line) begin
                $error("end_of_line: expected %0b, actual %0b",
                       want.end_of_line, got.end_of_line);
                errors++;
            end
        endfunction
    endclass

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    hrec_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    hrec_out_t m_payload;

    bit source_idles = 1'b1;
    bit sink_idles   = 1'b1;
    bit hold_request = 1'b0;
    int requests_sent = 0;

    hex_text_scoreboard sb = new();

    hex_record_encoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: checks accepted characters and stalls at random.
    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_char(m_payload);
            end
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = 300;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(sink_idles && $urandom_range(0, 99) < 30);
            end
        end
    end

    task automatic send_request(input hrec_in_t r);
        int gap;
        gap = (source_idles && $urandom_range(0, 99) < 30) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_request(r);
        requests_sent++;
    endtask

    task automatic send_data(input logic [15:0] addr, input logic [4:0] cnt,
                             input logic [7:0] data);
        hrec_in_t r;
        r.mode         = MODE_DATA;
        r.load_address = addr;
        r.byte_count   = cnt;
        r.data_byte    = data;
        send_request(r);
    endtask

    task automatic send_eof();
        hrec_in_t r;
        r      = hrec_in_t'({$urandom, $urandom});
        r.mode = MODE_EOF;
        send_request(r);
    endtask

    // A record of n bytes; the address and count after the first byte are random and ignored.
    task automatic send_record(input logic [15:0] addr, input logic [4:0] cnt, input int n);
        send_data(addr, cnt, 8'($urandom));
        for (int i = 1; i < n; i++) begin
            send_data(16'($urandom), 5'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int len;
        int kind;
        logic [4:0] cnt;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_eof();
        send_data(16'hFFFF, 5'd0, 8'hFF);
        send_data(16'h0000, 5'd1, 8'h00);
        send_data(16'h8001, 5'd2, 8'h80);
        send_data(16'h7FFE, 5'd9, 8'h7F);
        send_data(16'h1234, 5'd4, 8'hA5);
        send_data(16'h5678, 5'd4, 8'h5A);
        send_eof();
        for (int i = 0; i < MAX_BYTES; i++) begin
            send_data(16'hC3A0 ^ 16'(i), 5'd31, 8'(i * 17));
        end

        while (requests_sent < RANDOM_ITEMS) begin
            source_idles = !(requests_sent >= 110 && requests_sent < 180);
            sink_idles   = source_idles;
            if (requests_sent >= 60 && requests_sent < 62) begin
                hold_request = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 6) begin
                send_eof();
            end else begin
                cnt = (kind < 80) ? 5'($urandom_range(1, 16)) : 5'($urandom_range(0, 31));
                len = (cnt == 0) ? 1 : ((cnt > MAX_BYTES) ? MAX_BYTES : cnt);
                if (len > 1 && $urandom_range(0, 99) < 8) begin
                    send_record(16'($urandom), cnt, $urandom_range(1, len - 1));
                    send_eof();
                end else begin
                    send_record(16'($urandom), cnt, len);
                end
            end
        end
        s_valid <= 1'b0;

        while (sb.text_queue.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);

        $display("Sent %0d requests: %0d data records closed, %0d end-of-file records.",
                 requests_sent, sb.closed, sb.eof_seen);
        $display("Checked %0d characters, including a long receiver hold-off.", sb.checked);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
